/* hw/rtl/pdt_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and microcode ROM for the PID duty trim block.
package pdt_pkg;

    // Field and datapath widths
    localparam int GAIN_W  = 16;
    localparam int FREQ_W  = 16;
    localparam int SPEED_W = 10;
    localparam int DUTY_W  = 10;
    localparam int CORR_W  = 8;
    localparam int MEAS_W  = 16;
    localparam int PROD_W  = FREQ_W + SPEED_W;   // freq * full scale speed
    localparam int ERR_W   = 17;
    localparam int SUM_W   = 12;
    localparam int DIFF_W  = 18;
    localparam int MOP_W   = 24;                 // multiplier operand
    localparam int MUL_W   = GAIN_W + MOP_W;
    localparam int ACC_W   = 42;
    localparam int MAG_W   = 10;
    localparam int PC_W    = 4;
    localparam int CNT_W   = $clog2(PROD_W);
    localparam int CFG_AW  = 5;
    localparam int CFG_DW  = 32;

    // Register indexes (byte address / 4)
    localparam logic [2:0] REG_GAIN_P     = 3'd0;
    localparam logic [2:0] REG_GAIN_I     = 3'd1;
    localparam logic [2:0] REG_GAIN_D     = 3'd2;
    localparam logic [2:0] REG_FS_FREQ    = 3'd3;
    localparam logic [2:0] REG_FS_SPEED   = 3'd4;
    localparam logic [2:0] REG_DUTY_LIMIT = 3'd5;

    localparam logic signed [SUM_W-1:0] SUM_LIMIT  = 12'sd2000;
    localparam logic [MAG_W-1:0]        MAG_CAP    = 10'd1000;  // 100 * 10 after >>8
    localparam logic [7:0]              RECIP_10   = 8'd205;    // /10 as *205 >> 11
    localparam int                      RECIP_SH   = 11;

    typedef struct packed {
        logic signed [GAIN_W-1:0] gain_p;
        logic signed [GAIN_W-1:0] gain_i;
        logic signed [GAIN_W-1:0] gain_d;
        logic [FREQ_W-1:0]        fs_freq;
        logic [SPEED_W-1:0]       fs_speed;
        logic [DUTY_W-1:0]        duty_limit;
    } cfg_t;

    typedef enum logic [3:0] {
        U_NOP,
        U_FREQ,
        U_SCALE,
        U_DIV,
        U_MEAS,
        U_ERR,
        U_SUM,
        U_MUL_P,
        U_MUL_I,
        U_MUL_D,
        U_ACC,
        U_MAG,
        U_CORR,
        U_DUTY,
        U_CLEAR
    } uop_t;

    typedef enum logic [1:0] {
        J_NONE,
        J_ALWAYS,
        J_CLEAR,
        J_DIV_MORE
    } jcond_t;

    typedef struct packed {
        uop_t             uop;
        jcond_t           jcond;
        logic [PC_W-1:0]  target;
        logic             done;
    } ctrl_word_t;

    typedef struct packed {
        logic is_clear;
        logic div_more;
    } dp_flags_t;

    localparam logic [PC_W-1:0] PC_START = 4'd0;
    localparam logic [PC_W-1:0] PC_DIV   = 4'd2;
    localparam logic [PC_W-1:0] PC_CLEAR = 4'd13;
    localparam logic [PC_W-1:0] PC_DONE  = 4'd14;

    function automatic ctrl_word_t ucode(input logic [PC_W-1:0] pc);
        ctrl_word_t cw;
        cw = '{uop: U_NOP, jcond: J_NONE, target: PC_START, done: 1'b0};
        unique case (pc)
            4'd0:  cw = '{uop: U_FREQ,  jcond: J_CLEAR,    target: PC_CLEAR, done: 1'b0};
            4'd1:  cw = '{uop: U_SCALE, jcond: J_NONE,     target: PC_START, done: 1'b0};
            4'd2:  cw = '{uop: U_DIV,   jcond: J_DIV_MORE, target: PC_DIV,   done: 1'b0};
            4'd3:  cw = '{uop: U_MEAS,  jcond: J_NONE,     target: PC_START, done: 1'b0};
            4'd4:  cw = '{uop: U_ERR,   jcond: J_NONE,     target: PC_START, done: 1'b0};
            4'd5:  cw = '{uop: U_SUM,   jcond: J_NONE,     target: PC_START, done: 1'b0};
            4'd6:  cw = '{uop: U_MUL_P, jcond: J_NONE,     target: PC_START, done: 1'b0};
            4'd7:  cw = '{uop: U_MUL_I, jcond: J_NONE,     target: PC_START, done: 1'b0};
            4'd8:  cw = '{uop: U_MUL_D, jcond: J_NONE,     target: PC_START, done: 1'b0};
            4'd9:  cw = '{uop: U_ACC,   jcond: J_NONE,     target: PC_START, done: 1'b0};
            4'd10: cw = '{uop: U_MAG,   jcond: J_NONE,     target: PC_START, done: 1'b0};
            4'd11: cw = '{uop: U_CORR,  jcond: J_NONE,     target: PC_START, done: 1'b0};
            4'd12: cw = '{uop: U_DUTY,  jcond: J_ALWAYS,   target: PC_DONE,  done: 1'b0};
            4'd13: cw = '{uop: U_CLEAR, jcond: J_NONE,     target: PC_START, done: 1'b0};
            default: cw = '{uop: U_NOP, jcond: J_NONE,     target: PC_START, done: 1'b1};
        endcase
        return cw;
    endfunction

endpackage

/* hw/rtl/pdt_div.sv */
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per step.
module pdt_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         step,
    input  logic [pdt_pkg::PROD_W-1:0]   dividend,
    input  logic [pdt_pkg::FREQ_W-1:0]   divisor,
    output logic [pdt_pkg::PROD_W-1:0]   quotient,
    output logic                         more
);
    import pdt_pkg::*;

    logic [PROD_W-1:0] dq_reg;
    logic [FREQ_W-1:0] rem_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [FREQ_W:0]   rem_sh;
    logic [FREQ_W:0]   rem_sub;
    logic              fits;

    assign rem_sh  = {rem_reg, dq_reg[PROD_W-1]};
    assign rem_sub = rem_sh - {1'b0, divisor};
    assign fits    = rem_sh >= {1'b0, divisor};

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dq_reg  <= dividend;
            rem_reg <= '0;
        end
        else if (step)
        begin
            // quotient bits shift in as the dividend shifts out
            dq_reg  <= {dq_reg[PROD_W-2:0], fits};
            rem_reg <= fits ? rem_sub[FREQ_W-1:0] : rem_sh[FREQ_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CNT_W'(PROD_W - 1);
        end
        else if (step && (cnt_reg != '0))
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    assign quotient = dq_reg;
    assign more     = cnt_reg != '0;

endmodule

/* hw/rtl/pdt_seq.sv */
`timescale 1ns / 1ps
// Microcode step counter with conditional jumps.
module pdt_seq (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step_en,
    input  pdt_pkg::dp_flags_t     flags,
    output pdt_pkg::ctrl_word_t    cw
);
    import pdt_pkg::*;

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            take;

    assign cw = ucode(pc_reg);

    always_comb
    begin
        unique case (cw.jcond)
            J_NONE:     take = 1'b0;
            J_ALWAYS:   take = 1'b1;
            J_CLEAR:    take = flags.is_clear;
            J_DIV_MORE: take = flags.div_more;
        endcase
    end

    always_comb
    begin
        priority if (!step_en)
            pc_next = pc_reg;
        else if (cw.done)
            pc_next = PC_START;
        else if (take)
            pc_next = cw.target;
        else
            pc_next = pc_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= PC_START;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

/* hw/rtl/pdt_dp.sv */
`timescale 1ns / 1ps
// Datapath: speed scaling, error terms, shared multiplier and output clamps.
module pdt_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  logic                          in_op,
    input  logic [pdt_pkg::FREQ_W-1:0]    in_pulses,
    input  logic [pdt_pkg::SPEED_W-1:0]   in_target,
    input  logic [pdt_pkg::DUTY_W-1:0]    in_base,
    input  logic                          step_en,
    input  pdt_pkg::ctrl_word_t           cw,
    input  pdt_pkg::cfg_t                 cfg,
    output pdt_pkg::dp_flags_t            flags,
    output logic [pdt_pkg::MEAS_W-1:0]    measured,
    output logic [pdt_pkg::CORR_W-1:0]    corr,
    output logic [pdt_pkg::DUTY_W-1:0]    duty
);
    import pdt_pkg::*;

    logic                     op_reg;
    logic [FREQ_W-1:0]        pulses_reg;
    logic [SPEED_W-1:0]       target_reg;
    logic [DUTY_W-1:0]        base_reg;

    logic [FREQ_W-1:0]        freq_reg;
    logic [MEAS_W-1:0]        measured_reg;
    logic signed [ERR_W-1:0]  e_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [DIFF_W-1:0] diff_reg;
    logic signed [MUL_W-1:0]  mul_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     neg_reg;
    logic [MAG_W-1:0]         mag_reg;
    logic [CORR_W-1:0]        corr_reg;
    logic [DUTY_W-1:0]        duty_reg;
    logic signed [SUM_W-1:0]  error_sum_reg;
    logic signed [ERR_W-1:0]  last_error_reg;

    logic [FREQ_W+3:0]        freq_x10;
    logic [FREQ_W-1:0]        freq_next;
    logic [PROD_W-1:0]        prod;
    logic [FREQ_W-1:0]        divisor;
    logic [PROD_W-1:0]        quot;
    logic                     div_more;
    logic [MEAS_W-1:0]        measured_next;
    logic signed [ERR_W-1:0]  e_next;
    logic signed [SUM_W+5:0]  sum_wide;
    logic signed [SUM_W-1:0]  sum_next;
    logic signed [DIFF_W-1:0] diff_next;
    logic signed [MOP_W-1:0]  e_ext;
    logic signed [MOP_W-1:0]  sum_ext;
    logic signed [MOP_W-1:0]  diff_ext;
    logic signed [GAIN_W-1:0] mul_gain;
    logic signed [MOP_W-1:0]  mul_op;
    logic signed [MUL_W-1:0]  mul_next;
    logic signed [ACC_W-1:0]  acc_sum;
    logic [ACC_W-1:0]         acc_abs;
    logic [MAG_W-1:0]         mag_next;
    logic [17:0]              recip_prod;
    logic [CORR_W-2:0]        quo10;
    logic [CORR_W-1:0]        corr_next;
    logic signed [DUTY_W+1:0] duty_sum;
    logic [DUTY_W-1:0]        duty_next;

    // frequency = count * 10, saturating
    assign freq_x10  = {1'b0, pulses_reg, 3'b000} + {3'b000, pulses_reg, 1'b0};
    assign freq_next = (|freq_x10[FREQ_W+3:FREQ_W]) ? '1 : freq_x10[FREQ_W-1:0];

    assign prod    = PROD_W'(freq_reg) * PROD_W'(cfg.fs_speed);
    assign divisor = (cfg.fs_freq == '0) ? FREQ_W'(1) : cfg.fs_freq;

    pdt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (step_en && (cw.uop == U_SCALE)),
        .step     (step_en && (cw.uop == U_DIV)),
        .dividend (prod),
        .divisor  (divisor),
        .quotient (quot),
        .more     (div_more)
    );

    assign measured_next = (|quot[PROD_W-1:MEAS_W]) ? '1 : quot[MEAS_W-1:0];
    assign e_next = $signed({{(ERR_W-SPEED_W){1'b0}}, target_reg})
                  - $signed({1'b0, measured_reg});

    // error sum with anti-windup clamp
    assign sum_wide = $signed({{6{error_sum_reg[SUM_W-1]}}, error_sum_reg})
                    + $signed({e_reg[ERR_W-1], e_reg});
    always_comb
    begin
        priority if (sum_wide > $signed({{6{1'b0}}, SUM_LIMIT}))
            sum_next = SUM_LIMIT;
        else if (sum_wide < -$signed({{6{1'b0}}, SUM_LIMIT}))
            sum_next = -SUM_LIMIT;
        else
            sum_next = sum_wide[SUM_W-1:0];
    end

    assign diff_next = $signed({e_reg[ERR_W-1], e_reg})
                     - $signed({last_error_reg[ERR_W-1], last_error_reg});

    assign e_ext    = {{(MOP_W-ERR_W){e_reg[ERR_W-1]}}, e_reg};
    assign sum_ext  = {{(MOP_W-SUM_W){sum_reg[SUM_W-1]}}, sum_reg};
    assign diff_ext = {{(MOP_W-DIFF_W){diff_reg[DIFF_W-1]}}, diff_reg};

    // one shared multiplier; the scale factors 10 and 100 are folded into the operand
    always_comb
    begin
        unique case (cw.uop)
            U_MUL_P:
            begin
                mul_gain = cfg.gain_p;
                mul_op   = e_ext * 24'sd10;
            end
            U_MUL_I:
            begin
                mul_gain = cfg.gain_i;
                mul_op   = sum_ext;
            end
            U_MUL_D:
            begin
                mul_gain = cfg.gain_d;
                mul_op   = diff_ext * 24'sd100;
            end
            default:
            begin
                mul_gain = '0;
                mul_op   = '0;
            end
        endcase
    end

    assign mul_next = mul_gain * mul_op;
    assign acc_sum  = acc_reg + {{(ACC_W-MUL_W){mul_reg[MUL_W-1]}}, mul_reg};

    // |T| >> 8, capped at 1000 so that the /10 gives the +-100 limit
    assign acc_abs  = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
    assign mag_next = (acc_abs[ACC_W-1:8] >= (ACC_W-8)'(MAG_CAP)) ? MAG_CAP : acc_abs[17:8];

    assign recip_prod = 18'(mag_reg) * 18'(RECIP_10);
    assign quo10      = recip_prod[17:RECIP_SH];
    assign corr_next  = neg_reg ? CORR_W'(-{1'b0, quo10}) : {1'b0, quo10};

    assign duty_sum = $signed({2'b00, base_reg})
                    + $signed({{(DUTY_W+2-CORR_W){corr_reg[CORR_W-1]}}, corr_reg});
    always_comb
    begin
        priority if (duty_sum[DUTY_W+1])
            duty_next = '0;
        else if (duty_sum[DUTY_W:0] > {1'b0, cfg.duty_limit})
            duty_next = cfg.duty_limit;
        else
            duty_next = duty_sum[DUTY_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            op_reg     <= in_op;
            pulses_reg <= in_pulses;
            target_reg <= in_target;
            base_reg   <= in_base;
        end
        if (step_en)
        begin
            unique case (cw.uop)
                U_FREQ:  freq_reg     <= freq_next;
                U_MEAS:  measured_reg <= measured_next;
                U_ERR:   e_reg        <= e_next;
                U_SUM:
                begin
                    sum_reg  <= sum_next;
                    diff_reg <= diff_next;
                end
                U_MUL_P:
                begin
                    mul_reg <= mul_next;
                    acc_reg <= '0;
                end
                U_MUL_I, U_MUL_D:
                begin
                    mul_reg <= mul_next;
                    acc_reg <= acc_sum;
                end
                U_ACC:   acc_reg <= acc_sum;
                U_MAG:
                begin
                    mag_reg <= mag_next;
                    neg_reg <= acc_reg[ACC_W-1];
                end
                U_CORR:  corr_reg <= corr_next;
                U_DUTY:  duty_reg <= duty_next;
                U_CLEAR:
                begin
                    measured_reg <= '0;
                    corr_reg     <= '0;
                    duty_reg     <= '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_sum_reg  <= '0;
            last_error_reg <= '0;
        end
        else if (step_en && (cw.uop == U_DUTY))
        begin
            error_sum_reg  <= sum_reg;
            last_error_reg <= e_reg;
        end
        else if (step_en && (cw.uop == U_CLEAR))
        begin
            error_sum_reg  <= '0;
            last_error_reg <= '0;
        end
    end

    assign flags.is_clear = op_reg;
    assign flags.div_more = div_more;
    assign measured = measured_reg;
    assign corr     = corr_reg;
    assign duty     = duty_reg;

endmodule

/* hw/rtl/pid_duty_trim.sv */
`timescale 1ns / 1ps
// Top level of the PID duty trim block: config registers, stream ports, result register.
//
//  Channel   Direction  Transaction content
//  s_*       in         tuser: op; tdata: pulse_count, target_speed, base_duty
//  m_*       out        tdata: trimmed_duty, correction, measured_speed
//  APB       in/out     gain_p, gain_i, gain_d, full_scale_freq, full_scale_speed,
//                       duty_limit at byte addresses 0x00..0x14
//
// A trim sample runs the 26-step restoring divider for the speed scaling plus 13
// other microcode steps; a clear jumps from the first step to the clear step.
// One sample is in work at a time; s_tready returns together with m_tvalid, when the
// result is written to the output register, which holds it while m_tready is low.
// Reset clears the controller state and loads the register defaults.
module pid_duty_trim (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [39:0]                  s_tdata,   // pulse_count[15:0], target_speed[25:16],
                                                    // base_duty[35:26], zero pad
    input  logic                         s_tuser,   // op: 0 trim, 1 clear
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [39:0]                  m_tdata,   // trimmed_duty[9:0], correction[17:10],
                                                    // measured_speed[33:18], zero pad
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pdt_pkg::CFG_AW-1:0]   paddr,
    input  logic [pdt_pkg::CFG_DW-1:0]   pwdata,
    output logic [pdt_pkg::CFG_DW-1:0]   prdata,
    output logic                         pready
);
    import pdt_pkg::*;

    cfg_t               cfg_reg;
    logic               busy_reg;
    logic               out_valid_reg;
    logic [DUTY_W-1:0]  out_duty_reg;
    logic [CORR_W-1:0]  out_corr_reg;
    logic [MEAS_W-1:0]  out_meas_reg;

    ctrl_word_t         cw;
    dp_flags_t          flags;
    logic               accept;
    logic               step_en;
    logic               finish;
    logic               cfg_wr;
    logic [MEAS_W-1:0]  dp_meas;
    logic [CORR_W-1:0]  dp_corr;
    logic [DUTY_W-1:0]  dp_duty;

    assign pready   = 1'b1;
    assign s_tready = !busy_reg;
    assign accept   = s_tvalid && s_tready;
    // the final step waits while the result register is still full
    assign step_en  = busy_reg && !(cw.done && out_valid_reg && !m_tready);
    assign finish   = step_en && cw.done;
    assign cfg_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p     <= 16'sd256;
            cfg_reg.gain_i     <= '0;
            cfg_reg.gain_d     <= '0;
            cfg_reg.fs_freq    <= 16'd1000;
            cfg_reg.fs_speed   <= 10'd260;
            cfg_reg.duty_limit <= 10'd384;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:2])
                REG_GAIN_P:     cfg_reg.gain_p     <= pwdata[GAIN_W-1:0];
                REG_GAIN_I:     cfg_reg.gain_i     <= pwdata[GAIN_W-1:0];
                REG_GAIN_D:     cfg_reg.gain_d     <= pwdata[GAIN_W-1:0];
                REG_FS_FREQ:    cfg_reg.fs_freq    <= pwdata[FREQ_W-1:0];
                REG_FS_SPEED:   cfg_reg.fs_speed   <= pwdata[SPEED_W-1:0];
                REG_DUTY_LIMIT: cfg_reg.duty_limit <= pwdata[DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_GAIN_P:     prdata = CFG_DW'(cfg_reg.gain_p[GAIN_W-1:0]);
            REG_GAIN_I:     prdata = CFG_DW'(cfg_reg.gain_i[GAIN_W-1:0]);
            REG_GAIN_D:     prdata = CFG_DW'(cfg_reg.gain_d[GAIN_W-1:0]);
            REG_FS_FREQ:    prdata = CFG_DW'(cfg_reg.fs_freq);
            REG_FS_SPEED:   prdata = CFG_DW'(cfg_reg.fs_speed);
            REG_DUTY_LIMIT: prdata = CFG_DW'(cfg_reg.duty_limit);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                busy_reg <= 1'b1;
            else if (finish)
                busy_reg <= 1'b0;

            if (finish)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            out_duty_reg <= dp_duty;
            out_corr_reg <= dp_corr;
            out_meas_reg <= dp_meas;
        end
    end

    pdt_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .flags   (flags),
        .cw      (cw)
    );

    pdt_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .in_op     (s_tuser),
        .in_pulses (s_tdata[15:0]),
        .in_target (s_tdata[25:16]),
        .in_base   (s_tdata[35:26]),
        .step_en   (step_en),
        .cw        (cw),
        .cfg       (cfg_reg),
        .flags     (flags),
        .measured  (dp_meas),
        .corr      (dp_corr),
        .duty      (dp_duty)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b000000, out_meas_reg, out_corr_reg, out_duty_reg};

endmodule

/* hw/rtl/pdt_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the PID duty trim block and their bind.
module pdt_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [39:0]                  m_tdata,
    input  logic                         pready
);

    // one sample in work at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while a sample is in work");

    // no result can appear right after a transaction is taken
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !$rose(m_tvalid))
        else $error("result rose directly after input transaction");

    a_corr_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (($signed(m_tdata[17:10]) >= -8'sd100)
                   && ($signed(m_tdata[17:10]) <= 8'sd100)))
        else $error("correction outside +-100");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

endmodule

bind pid_duty_trim pdt_checker u_pdt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .pready   (pready)
);
